// File: hdl/pmf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the pulse matched filter.
// No dependencies.
package pmf_pkg;

  localparam int DEF_MAX_TAPS    = 64;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int IN_SAMPLE_W     = 16;
  localparam int FILT_W          = 38;
  localparam int OUT_TDATA_W     = 40;

  localparam logic KIND_TAP = 1'b0;
  localparam logic KIND_RX  = 1'b1;

  // per-step control broadcast along the cell row
  typedef struct packed {
    logic step;
    logic clear;
    logic tap_ld;
  } pmf_ctl_t;

  // valid and end-of-record tag that travels beside the data
  typedef struct packed {
    logic vld;
    logic last;
  } pmf_tag_t;

endpackage

// File: hdl/pmf_cell.sv
`timescale 1ns / 1ps
// One filter cell: one delay-line sample, one coefficient and one product register.
// Depends on pmf_pkg.
module pmf_cell
  import pmf_pkg::*;
#(
  parameter int IDX    = 0,
  parameter int SB     = DEF_SAMPLE_BITS,
  parameter int CNT_W  = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pmf_ctl_t             ctl,
  input  logic [CNT_W-1:0]     tap_cnt,
  input  logic signed [SB-1:0] x_in,
  input  logic signed [SB-1:0] h_in,
  output logic signed [SB-1:0] x_out,
  output logic signed [SB-1:0] h_out,
  output logic signed [2*SB-1:0] prod_out
);

  logic signed [SB-1:0]   x_r;
  logic signed [SB-1:0]   h_r;
  logic signed [2*SB-1:0] prod_r;
  logic signed [2*SB-1:0] prod_nxt;
  logic                   active;

  assign active   = (tap_cnt > CNT_W'(IDX));
  assign prod_nxt = h_r * x_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
    end else if (ctl.step) begin
      x_r <= ctl.clear ? '0 : x_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tap_ld) begin
      h_r <= h_in;
    end
    if (ctl.step) begin
      prod_r <= active ? prod_nxt : '0;
    end
  end

  assign x_out    = x_r;
  assign h_out    = h_r;
  assign prod_out = prod_r;

endmodule

// File: hdl/pmf_sum_tree.sv
`timescale 1ns / 1ps
// Registered binary adder tree over the cell products, one level per stage.
// Depends on pmf_pkg.
module pmf_sum_tree
  import pmf_pkg::*;
#(
  parameter int N_LEAF = DEF_MAX_TAPS,
  parameter int PW     = 2 * DEF_SAMPLE_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic signed [PW-1:0]     leaf [N_LEAF],
  input  pmf_tag_t                 tag_in,
  output logic signed [FILT_W-1:0] sum_out,
  output pmf_tag_t                 tag_out
);

  localparam int LEVELS = (N_LEAF > 1) ? $clog2(N_LEAF) : 0;
  localparam int LEAVES = 1 << LEVELS;

  logic signed [FILT_W-1:0] leaf_ext [LEAVES];

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < N_LEAF) begin : g_used
      assign leaf_ext[i] = {{(FILT_W-PW){leaf[i][PW-1]}}, leaf[i]};
    end else begin : g_pad
      assign leaf_ext[i] = '0;
    end
  end

  if (LEVELS == 0) begin : g_flat
    assign sum_out = leaf_ext[0];
    assign tag_out = tag_in;
  end else begin : g_tree
    // heap layout: node i has children 2i+1 and 2i+2, leaves follow the nodes
    logic signed [FILT_W-1:0] sum_r [LEAVES-1];
    logic signed [FILT_W-1:0] lhs   [LEAVES-1];
    logic signed [FILT_W-1:0] rhs   [LEAVES-1];
    pmf_tag_t                 tag_r [LEVELS];

    for (genvar i = 0; i < LEAVES - 1; i++) begin : g_node
      if (2 * i + 1 >= LEAVES - 1) begin : g_l_leaf
        assign lhs[i] = leaf_ext[2 * i + 1 - (LEAVES - 1)];
      end else begin : g_l_node
        assign lhs[i] = sum_r[2 * i + 1];
      end
      if (2 * i + 2 >= LEAVES - 1) begin : g_r_leaf
        assign rhs[i] = leaf_ext[2 * i + 2 - (LEAVES - 1)];
      end else begin : g_r_node
        assign rhs[i] = sum_r[2 * i + 2];
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          sum_r[i] <= lhs[i] + rhs[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        for (int l = 0; l < LEVELS; l++) begin
          tag_r[l] <= '0;
        end
      end else if (adv) begin
        tag_r[0] <= tag_in;
        for (int l = 1; l < LEVELS; l++) begin
          tag_r[l] <= tag_r[l-1];
        end
      end
    end

    assign sum_out = sum_r[0];
    assign tag_out = tag_r[LEVELS-1];
  end

endmodule

// File: hdl/pulse_matched_filter_core.sv
`timescale 1ns / 1ps
// Top level of the pulse matched filter: control, cell row, adder tree, output register.
// Depends on pmf_pkg, pmf_cell and pmf_sum_tree.
//
// Pulse taps (in_tuser = 0) load one per cycle while in_tready is high into a row of
// MAX_TAPS cells, shifting so that the row holds the pulse time-reversed; a tap gives no
// output. Received samples (in_tuser = 1) are taken one per cycle, also while in_tready
// is high, and each gives one output. After the last sample of a record (in_tlast) the
// block shifts M-1 zeros through the delay line for the convolution tail, M being the
// number of taps loaded, with in_tready low; the delay line is then cleared. The cell
// product is registered at the accepting edge, then passes through the adder tree levels
// and the output register. The whole pipeline holds while out_tvalid is high and
// out_tready is low, so in_tready then drops as well.
module pulse_matched_filter_core
  import pmf_pkg::*;
#(
  parameter int MAX_TAPS    = DEF_MAX_TAPS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_SAMPLE_W-1:0] in_tdata,   // [15:0] sample
  input  logic                   in_tuser,   // [0] kind
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [37:0] filtered, rest zero
  output logic                   out_tlast
);

  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int SB    = SAMPLE_BITS;

  logic                 adv;
  logic                 in_acc;
  logic                 tap_acc;
  logic                 rx_acc;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt, cnt_base;
  logic                 pc_r, pc_nxt;
  logic                 flush_r, flush_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  pmf_ctl_t             ctl;
  logic signed [SB-1:0] in_x;
  logic signed [SB-1:0] step_x;
  pmf_tag_t             s1_tag_r, s1_tag_nxt;
  pmf_tag_t             root_tag;
  logic signed [FILT_W-1:0] root_sum;
  logic                 out_vld_r;
  logic                 out_last_r;
  logic [FILT_W-1:0]    out_data_r;

  logic signed [SB-1:0]   x_chain [MAX_TAPS];
  logic signed [SB-1:0]   h_chain [MAX_TAPS];
  logic signed [2*SB-1:0] prod    [MAX_TAPS];

  assign adv     = !out_vld_r || out_tready;
  assign in_tready = adv && !flush_r;
  assign in_acc  = in_tvalid && in_tready;
  assign tap_acc = in_acc && (in_tuser == KIND_TAP);
  assign rx_acc  = in_acc && (in_tuser == KIND_RX);
  assign in_x    = signed'(in_tdata[SB-1:0]);
  assign step_x  = flush_r ? '0 : in_x;
  assign cnt_base = pc_r ? '0 : cnt_r;

  always_comb begin
    cnt_nxt    = cnt_r;
    pc_nxt     = pc_r;
    flush_nxt  = flush_r;
    rem_nxt    = rem_r;
    ctl        = '0;
    s1_tag_nxt = '0;
    if (tap_acc) begin
      pc_nxt = in_tlast;
      if (cnt_base < CNT_W'(MAX_TAPS)) begin
        cnt_nxt    = cnt_base + CNT_W'(1);
        ctl.tap_ld = 1'b1;
      end else begin
        cnt_nxt = cnt_base;
      end
    end else if (rx_acc) begin
      ctl.step = 1'b1;
      if (in_tlast) begin
        if (cnt_r > CNT_W'(1)) begin
          flush_nxt = 1'b1;
          rem_nxt   = cnt_r - CNT_W'(1);
        end else begin
          ctl.clear = 1'b1;
        end
      end
    end else if (flush_r && adv) begin
      ctl.step = 1'b1;
      rem_nxt  = rem_r - CNT_W'(1);
      if (rem_r == CNT_W'(1)) begin
        ctl.clear = 1'b1;
        flush_nxt = 1'b0;
      end
    end
    s1_tag_nxt.vld  = ctl.step;
    s1_tag_nxt.last = ctl.clear;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      pc_r       <= 1'b0;
      flush_r    <= 1'b0;
      rem_r      <= '0;
      s1_tag_r   <= '0;
      out_vld_r  <= 1'b0;
      out_last_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      pc_r    <= pc_nxt;
      flush_r <= flush_nxt;
      rem_r   <= rem_nxt;
      if (adv) begin
        s1_tag_r   <= s1_tag_nxt;
        out_vld_r  <= root_tag.vld;
        out_last_r <= root_tag.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= root_sum;
    end
  end

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    logic signed [SB-1:0] x_prev;
    logic signed [SB-1:0] h_prev;
    if (k == 0) begin : g_head
      assign x_prev = step_x;
      assign h_prev = in_x;
    end else begin : g_body
      assign x_prev = x_chain[k-1];
      assign h_prev = h_chain[k-1];
    end
    pmf_cell #(
      .IDX   (k),
      .SB    (SB),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .tap_cnt  (cnt_r),
      .x_in     (x_prev),
      .h_in     (h_prev),
      .x_out    (x_chain[k]),
      .h_out    (h_chain[k]),
      .prod_out (prod[k])
    );
  end

  pmf_sum_tree #(
    .N_LEAF (MAX_TAPS),
    .PW     (2 * SB)
  ) u_tree (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .leaf    (prod),
    .tag_in  (s1_tag_r),
    .sum_out (root_sum),
    .tag_out (root_tag)
  );

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W-FILT_W){1'b0}}, out_data_r};

  a_step_needs_adv: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step |-> adv)
    else $error("delay line stepped while the pipeline is stalled");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_TAPS))
    else $error("tap count beyond row length");

  a_flush_rem: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> (rem_r != '0))
    else $error("tail flush running with nothing left");

  a_flush_start: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_acc && in_tlast && (cnt_r > CNT_W'(1))) |=> (flush_r && !in_tready))
    else $error("final sample did not start the tail flush");

endmodule
